[hdl/http_response_header_parser_top_macros.svh]
// assertion macros for the response header parser
`ifndef HTTP_RESPONSE_HEADER_PARSER_TOP_MACROS_SVH
`define HTTP_RESPONSE_HEADER_PARSER_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS

// checked only outside reset
`define HRHP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("hrhp assertion failed");

// checked at every edge, reset included
`define HRHP_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("hrhp assertion failed");

`else

`define HRHP_ASSERT(lbl, prop)
`define HRHP_ASSERT_ALWAYS(lbl, prop)

`endif

`endif

[hdl/hrhp_pkg.sv]
// types and codes shared by the response header parser modules
package hrhp_pkg;

  typedef enum logic [4:0] {
    S_START, S_T1, S_T2, S_P, S_SLASH,
    S_MAJ0, S_MAJ, S_MIN0, S_MIN, S_CODE0, S_CODE,
    S_PHR0, S_PHR, S_NL1, S_LINE, S_LWS, S_NAME, S_SPACE, S_VALUE,
    S_NL2, S_NL3, S_BODY, S_DONE, S_FAIL
  } hrhp_state_t;

  localparam logic [2:0] CLS_SYNTAX  = 3'd0;
  localparam logic [2:0] CLS_PHRASE  = 3'd1;
  localparam logic [2:0] CLS_NAME    = 3'd2;
  localparam logic [2:0] CLS_VALUE   = 3'd3;
  localparam logic [2:0] CLS_BODY    = 3'd4;
  localparam logic [2:0] CLS_IGNORED = 3'd5;

  localparam logic [1:0] PST_BUSY   = 2'd0;
  localparam logic [1:0] PST_DONE   = 2'd1;
  localparam logic [1:0] PST_FAILED = 2'd2;

  localparam logic [3:0] ERR_NONE    = 4'd0;
  localparam logic [3:0] ERR_FIRST   = 4'd1;
  localparam logic [3:0] ERR_VERSION = 4'd2;
  localparam logic [3:0] ERR_DIGIT   = 4'd3;
  localparam logic [3:0] ERR_PHRASE  = 4'd4;
  localparam logic [3:0] ERR_NO_LF   = 4'd5;
  localparam logic [3:0] ERR_NAME    = 4'd6;
  localparam logic [3:0] ERR_CONTROL = 4'd7;
  localparam logic [3:0] ERR_NO_BODY = 4'd8;

  localparam logic [3:0] CL_NAME_LEN = 4'd14;

  typedef struct packed {
    logic       step;
    logic       new_message;
    logic [7:0] data_byte;
  } hrhp_item_t;

  // first field in the highest bits
  typedef struct packed {
    logic [31:0] body_length;
    logic [15:0] status_code;
    logic [7:0]  version_minor;
    logic [7:0]  version_major;
    logic        header_start;
    logic [3:0]  error_code;
    logic [1:0]  parse_status;
    logic [2:0]  byte_class;
  } hrhp_result_t;

endpackage

[hdl/hrhp_core.sv]
// parser state registers and the per-byte next-state logic
module hrhp_core #(
  parameter int LENGTH_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  requires_body,
  input  hrhp_pkg::hrhp_item_t  item,
  output hrhp_pkg::hrhp_result_t result
);

  hrhp_pkg::hrhp_state_t  state, state_next, b_state;
  logic [7:0]             major, major_next, b_major;
  logic [7:0]             minor, minor_next, b_minor;
  logic [15:0]            code, code_next, b_code;
  logic [3:0]             match_idx, match_idx_next, b_idx;
  logic                   match_ok, match_ok_next, b_ok;
  logic                   length_seen, length_seen_next, b_seen;
  logic [LENGTH_BITS-1:0] length_acc, length_acc_next, b_len;
  logic [LENGTH_BITS-1:0] body_count, body_count_next, b_body;
  logic                   any_header, any_header_next, b_any;
  logic [3:0]             last_error, last_error_next, b_err;

  logic [7:0]             c, lc;
  logic [3:0]             d;
  logic                   c_digit, c_ctl, c_text, c_special;
  logic [11:0]            major_mul, minor_mul;
  logic [19:0]            code_mul;
  logic [LENGTH_BITS+3:0] len_mul;
  logic [7:0]             major_sat, minor_sat;
  logic [15:0]            code_sat;
  logic [LENGTH_BITS-1:0] len_sat, body_inc;
  logic                   name_hit;
  logic [2:0]             cls;
  logic                   hstart;

  function automatic logic [7:0] name_at(input logic [3:0] idx);
    logic [7:0] ch;
    unique case (idx)
      4'd0:    ch = "c";
      4'd1:    ch = "o";
      4'd2:    ch = "n";
      4'd3:    ch = "t";
      4'd4:    ch = "e";
      4'd5:    ch = "n";
      4'd6:    ch = "t";
      4'd7:    ch = "-";
      4'd8:    ch = "l";
      4'd9:    ch = "e";
      4'd10:   ch = "n";
      4'd11:   ch = "g";
      4'd12:   ch = "t";
      4'd13:   ch = "h";
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic logic is_special(input logic [7:0] ch);
    logic r;
    unique case (ch)
      "(", ")", "<", ">", "@", ",", ";", ":", "\\", "\"", "/", "[", "]",
      "?", "=", "{", "}", " ", "\t": r = 1'b1;
      default:                      r = 1'b0;
    endcase
    return r;
  endfunction

  // new_message clears everything before this byte is applied
  always_comb begin
    if (item.new_message) begin
      b_state = hrhp_pkg::S_START;
      b_major = '0;
      b_minor = '0;
      b_code  = '0;
      b_idx   = '0;
      b_ok    = 1'b0;
      b_seen  = 1'b0;
      b_len   = '0;
      b_body  = '0;
      b_any   = 1'b0;
      b_err   = hrhp_pkg::ERR_NONE;
    end else begin
      b_state = state;
      b_major = major;
      b_minor = minor;
      b_code  = code;
      b_idx   = match_idx;
      b_ok    = match_ok;
      b_seen  = length_seen;
      b_len   = length_acc;
      b_body  = body_count;
      b_any   = any_header;
      b_err   = last_error;
    end
  end

  assign c         = item.data_byte;
  assign lc        = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
  assign d         = 4'(c - "0");
  assign c_digit   = (c >= "0") && (c <= "9");
  assign c_ctl     = (c < 8'd32) || (c == 8'd127);
  assign c_text    = !c[7] && !c_ctl;
  assign c_special = is_special(c);

  // acc * 10 + d, saturated when it no longer fits
  assign major_mul = ({4'b0, b_major} << 3) + ({4'b0, b_major} << 1) + 12'(d);
  assign minor_mul = ({4'b0, b_minor} << 3) + ({4'b0, b_minor} << 1) + 12'(d);
  assign code_mul  = ({4'b0, b_code} << 3) + ({4'b0, b_code} << 1) + 20'(d);
  assign len_mul   = ({4'b0, b_len} << 3) + ({4'b0, b_len} << 1) + (LENGTH_BITS+4)'(d);
  assign major_sat = (|major_mul[11:8]) ? '1 : major_mul[7:0];
  assign minor_sat = (|minor_mul[11:8]) ? '1 : minor_mul[7:0];
  assign code_sat  = (|code_mul[19:16]) ? '1 : code_mul[15:0];
  assign len_sat   = (|len_mul[LENGTH_BITS+3:LENGTH_BITS]) ? '1 : len_mul[LENGTH_BITS-1:0];
  assign body_inc  = b_body + LENGTH_BITS'(1);
  assign name_hit  = (b_idx < hrhp_pkg::CL_NAME_LEN) && (lc == name_at(b_idx));

  always_comb begin
    state_next       = b_state;
    major_next       = b_major;
    minor_next       = b_minor;
    code_next        = b_code;
    match_idx_next   = b_idx;
    match_ok_next    = b_ok;
    length_seen_next = b_seen;
    length_acc_next  = b_len;
    body_count_next  = b_body;
    any_header_next  = b_any;
    last_error_next  = b_err;
    cls              = hrhp_pkg::CLS_SYNTAX;
    hstart           = 1'b0;

    unique case (b_state)
      hrhp_pkg::S_START: begin
        if (c == "H") state_next = hrhp_pkg::S_T1;
        else begin
          state_next = hrhp_pkg::S_FAIL;
          last_error_next = hrhp_pkg::ERR_FIRST;
        end
      end
      hrhp_pkg::S_T1, hrhp_pkg::S_T2, hrhp_pkg::S_P, hrhp_pkg::S_SLASH: begin
        priority if (b_state == hrhp_pkg::S_T1 && c == "T") begin
          state_next = hrhp_pkg::S_T2;
        end else if (b_state == hrhp_pkg::S_T2 && c == "T") begin
          state_next = hrhp_pkg::S_P;
        end else if (b_state == hrhp_pkg::S_P && c == "P") begin
          state_next = hrhp_pkg::S_SLASH;
        end else if (b_state == hrhp_pkg::S_SLASH && c == "/") begin
          major_next = '0;
          minor_next = '0;
          state_next = hrhp_pkg::S_MAJ0;
        end else begin
          state_next = hrhp_pkg::S_FAIL;
          last_error_next = hrhp_pkg::ERR_VERSION;
        end
      end
      hrhp_pkg::S_MAJ0, hrhp_pkg::S_MAJ: begin
        if (b_state == hrhp_pkg::S_MAJ && c == ".") begin
          state_next = hrhp_pkg::S_MIN0;
        end else if (c_digit) begin
          major_next = major_sat;
          state_next = hrhp_pkg::S_MAJ;
        end else begin
          state_next = hrhp_pkg::S_FAIL;
          last_error_next = hrhp_pkg::ERR_DIGIT;
        end
      end
      hrhp_pkg::S_MIN0, hrhp_pkg::S_MIN: begin
        if (b_state == hrhp_pkg::S_MIN && c == " ") begin
          state_next = hrhp_pkg::S_CODE0;
        end else if (c_digit) begin
          minor_next = minor_sat;
          state_next = hrhp_pkg::S_MIN;
        end else begin
          state_next = hrhp_pkg::S_FAIL;
          last_error_next = hrhp_pkg::ERR_DIGIT;
        end
      end
      hrhp_pkg::S_CODE0, hrhp_pkg::S_CODE: begin
        if (b_state == hrhp_pkg::S_CODE && c == " ") begin
          state_next = hrhp_pkg::S_PHR0;
        end else if (c_digit) begin
          code_next = code_sat;
          state_next = hrhp_pkg::S_CODE;
        end else begin
          state_next = hrhp_pkg::S_FAIL;
          last_error_next = hrhp_pkg::ERR_DIGIT;
        end
      end
      hrhp_pkg::S_PHR0, hrhp_pkg::S_PHR: begin
        priority if (b_state == hrhp_pkg::S_PHR && c == "\r") begin
          state_next = hrhp_pkg::S_NL1;
        end else if (!c_text) begin
          state_next = hrhp_pkg::S_FAIL;
          last_error_next = hrhp_pkg::ERR_PHRASE;
        end else begin
          cls = hrhp_pkg::CLS_PHRASE;
          state_next = hrhp_pkg::S_PHR;
        end
      end
      hrhp_pkg::S_NL1, hrhp_pkg::S_NL2: begin
        if (c == "\n") state_next = hrhp_pkg::S_LINE;
        else begin
          state_next = hrhp_pkg::S_FAIL;
          last_error_next = hrhp_pkg::ERR_NO_LF;
        end
      end
      hrhp_pkg::S_LINE: begin
        priority if (c == "\r") begin
          state_next = hrhp_pkg::S_NL3;
        end else if (b_any && (c == " " || c == "\t")) begin
          state_next = hrhp_pkg::S_LWS;
        end else if (!c_text || c_special) begin
          state_next = hrhp_pkg::S_FAIL;
          last_error_next = hrhp_pkg::ERR_NAME;
        end else begin
          any_header_next = 1'b1;
          if (lc == name_at(4'd0)) begin
            match_ok_next  = 1'b1;
            match_idx_next = 4'd1;
          end else begin
            match_ok_next  = 1'b0;
            match_idx_next = 4'd0;
          end
          cls        = hrhp_pkg::CLS_NAME;
          hstart     = 1'b1;
          state_next = hrhp_pkg::S_NAME;
        end
      end
      hrhp_pkg::S_NAME: begin
        priority if (c == ":") begin
          match_ok_next = b_ok && (b_idx == hrhp_pkg::CL_NAME_LEN);
          if (b_ok && (b_idx == hrhp_pkg::CL_NAME_LEN)) begin
            length_seen_next = 1'b0;
            length_acc_next  = '0;
          end
          state_next = hrhp_pkg::S_SPACE;
        end else if (!c_text || c_special) begin
          state_next = hrhp_pkg::S_FAIL;
          last_error_next = hrhp_pkg::ERR_NAME;
        end else begin
          if (b_ok && name_hit) match_idx_next = b_idx + 4'd1;
          else match_ok_next = 1'b0;
          cls = hrhp_pkg::CLS_NAME;
        end
      end
      hrhp_pkg::S_LWS, hrhp_pkg::S_SPACE, hrhp_pkg::S_VALUE: begin
        priority if (c == "\r") begin
          state_next = hrhp_pkg::S_NL2;
        end else if ((c == " " && b_state != hrhp_pkg::S_VALUE) ||
                     (c == "\t" && b_state == hrhp_pkg::S_LWS)) begin
          state_next = b_state;
        end else if (c_ctl) begin
          state_next = hrhp_pkg::S_FAIL;
          last_error_next = hrhp_pkg::ERR_CONTROL;
        end else begin
          if (b_ok) begin
            if (c_digit) begin
              length_seen_next = 1'b1;
              length_acc_next  = len_sat;
            end else begin
              match_ok_next    = 1'b0;
              length_seen_next = 1'b0;
              length_acc_next  = '0;
            end
          end
          cls        = hrhp_pkg::CLS_VALUE;
          state_next = hrhp_pkg::S_VALUE;
        end
      end
      hrhp_pkg::S_NL3: begin
        priority if (c != "\n") begin
          state_next = hrhp_pkg::S_FAIL;
          last_error_next = hrhp_pkg::ERR_NO_LF;
        end else if (b_seen) begin
          body_count_next = '0;
          state_next = (|b_len) ? hrhp_pkg::S_BODY : hrhp_pkg::S_DONE;
        end else if (requires_body) begin
          state_next = hrhp_pkg::S_FAIL;
          last_error_next = hrhp_pkg::ERR_NO_BODY;
        end else begin
          state_next = hrhp_pkg::S_DONE;
        end
      end
      hrhp_pkg::S_BODY: begin
        cls = hrhp_pkg::CLS_BODY;
        body_count_next = body_inc;
        if (body_inc >= b_len) state_next = hrhp_pkg::S_DONE;
      end
      default: begin
        cls = hrhp_pkg::CLS_IGNORED;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= hrhp_pkg::S_START;
      major       <= '0;
      minor       <= '0;
      code        <= '0;
      match_idx   <= '0;
      match_ok    <= 1'b0;
      length_seen <= 1'b0;
      length_acc  <= '0;
      body_count  <= '0;
      any_header  <= 1'b0;
      last_error  <= hrhp_pkg::ERR_NONE;
    end else if (item.step) begin
      state       <= state_next;
      major       <= major_next;
      minor       <= minor_next;
      code        <= code_next;
      match_idx   <= match_idx_next;
      match_ok    <= match_ok_next;
      length_seen <= length_seen_next;
      length_acc  <= length_acc_next;
      body_count  <= body_count_next;
      any_header  <= any_header_next;
      last_error  <= last_error_next;
    end
  end

  generate
    if (LENGTH_BITS > 32) begin : g_len_wide
      assign result.body_length = (|length_acc_next[LENGTH_BITS-1:32]) ? '1
                                                                      : length_acc_next[31:0];
    end else begin : g_len_narrow
      assign result.body_length = 32'(length_acc_next);
    end
  endgenerate

  assign result.byte_class    = cls;
  assign result.parse_status  = (state_next == hrhp_pkg::S_FAIL) ? hrhp_pkg::PST_FAILED :
                                (state_next == hrhp_pkg::S_DONE) ? hrhp_pkg::PST_DONE :
                                                                   hrhp_pkg::PST_BUSY;
  assign result.error_code    = last_error_next;
  assign result.header_start  = hstart;
  assign result.version_major = major_next;
  assign result.version_minor = minor_next;
  assign result.status_code   = code_next;

endmodule

[hdl/http_response_header_parser_top.sv]
// top level of the response header parser: input stage, result stage, config register
//
// One response byte per transfer, one result per byte. A byte is taken every cycle as
// long as results are drained; the result of a byte reaches the output through the
// input register, then the result register fed by the per-byte state update.
// The sustained rate of one byte per cycle is set by the state update, whose longest
// path is the Content-Length accumulate (times ten plus digit) and the body counter
// increment and compare, both LENGTH_BITS wide. Asserting tuser with a byte restarts
// parsing with that byte as the first of a new message. The requires_body register
// is written through cfg_wr_en/cfg_wr_data; the user must write it only while no byte
// is in flight, which the block itself does not enforce.
`include "http_response_header_parser_top_macros.svh"

module http_response_header_parser_top #(
  parameter int LENGTH_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,    // requires_body
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // data_byte
  input  logic        s_axis_tuser,   // new_message
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // byte_class[2:0], parse_status[4:3], error_code[8:5], header_start[9],
  // version_major[17:10], version_minor[25:18], status_code[41:26],
  // body_length[73:42], zero fill[79:74]
  output logic [79:0] m_axis_tdata
);

  logic                   requires_body;
  logic                   in_valid;
  logic [7:0]             in_byte;
  logic                   in_new;
  logic                   advance;
  hrhp_pkg::hrhp_item_t   item;
  hrhp_pkg::hrhp_result_t core_result;
  hrhp_pkg::hrhp_result_t out_result;
  logic                   out_valid;

  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  assign item.step        = advance;
  assign item.new_message = in_new;
  assign item.data_byte   = in_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      requires_body <= 1'b0;
    end else if (cfg_wr_en) begin
      requires_body <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte <= s_axis_tdata;
      in_new  <= s_axis_tuser;
    end
  end

  hrhp_core #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_core (
    .clk           (clk),
    .rst           (rst),
    .requires_body (requires_body),
    .item          (item),
    .result        (core_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_result <= core_result;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {6'b0, out_result};

  `HRHP_ASSERT_ALWAYS(a_reset_clears_out, rst |=> !m_axis_tvalid)
  `HRHP_ASSERT(a_fail_has_code,
    (m_axis_tvalid && out_result.parse_status == hrhp_pkg::PST_FAILED)
      |-> (out_result.error_code != hrhp_pkg::ERR_NONE))
  `HRHP_ASSERT(a_code_means_fail,
    (m_axis_tvalid && out_result.error_code != hrhp_pkg::ERR_NONE)
      |-> (out_result.parse_status == hrhp_pkg::PST_FAILED))
  `HRHP_ASSERT(a_body_not_failed,
    (m_axis_tvalid && out_result.byte_class == hrhp_pkg::CLS_BODY)
      |-> (out_result.parse_status != hrhp_pkg::PST_FAILED))
  `HRHP_ASSERT(a_hstart_is_name,
    (m_axis_tvalid && out_result.header_start)
      |-> (out_result.byte_class == hrhp_pkg::CLS_NAME))

endmodule
